// ----- design/bsc_pkg.sv -----
// shared widths, constants and types of the barometric compensation block
`timescale 1ns / 1ps

package bsc_pkg;

	// field widths
	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int VAL_W   = 24;
	localparam int DT_W    = RAW_W + 1;
	localparam int NUM_COEF = 6;
	localparam int CFG_IDX_W = 3;

	// serial multiplier: signed multiplicand, unsigned multiplier, lsb first
	localparam int MCAND_W = 35;
	localparam int MPL_W   = RAW_W;
	localparam int ACC_W   = MCAND_W + 1;
	localparam int PROD_W  = ACC_W + MPL_W;
	localparam int CNT_W   = $clog2(MPL_W + 1);

	// a coefficient product comes out scaled up by the unused multiplier bits
	localparam int COEF_ALIGN = MPL_W - COEF_W;

	localparam int C5_SHIFT   = 8;
	localparam int C2_SHIFT   = 16;
	localparam int C1_SHIFT   = 15;
	localparam int TEMP_SHIFT = 23 + COEF_ALIGN;
	localparam int OFF_SHIFT  = 7 + COEF_ALIGN;
	localparam int SENS_SHIFT = 8 + COEF_ALIGN;
	localparam int PRES_SHIFT = 21;
	localparam int FINAL_SHIFT = 15;
	localparam int DIFF_W     = 40;

	localparam logic signed [VAL_W-1:0] TEMP_OFFSET = 24'sd2000;
	localparam logic signed [VAL_W-1:0] TEMP_MIN    = -24'sd5000;
	localparam logic signed [VAL_W-1:0] TEMP_MAX    = 24'sd7000;
	localparam logic signed [VAL_W-1:0] PRES_MIN    = 24'sd30000;
	localparam logic signed [VAL_W-1:0] PRES_MAX    = 24'sd115000;

	localparam logic KIND_TEMP = 1'b0;
	localparam logic KIND_PRES = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} coef_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] c1;
		logic [COEF_W-1:0] c2;
		logic [COEF_W-1:0] c3;
		logic [COEF_W-1:0] c4;
		logic [COEF_W-1:0] c5;
		logic [COEF_W-1:0] c6;
	} coef_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
	} mul_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

endpackage

// ----- design/bsc_coef_regs.sv -----
// calibration coefficient register file
`timescale 1ns / 1ps

module bsc_coef_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bsc_pkg::COEF_W-1:0]     wr_data,
	output bsc_pkg::coef_t                 coef
);
	import bsc_pkg::*;

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_C1: coef_q.c1 <= wr_data;
				REG_C2: coef_q.c2 <= wr_data;
				REG_C3: coef_q.c3 <= wr_data;
				REG_C4: coef_q.c4 <= wr_data;
				REG_C5: coef_q.c5 <= wr_data;
				REG_C6: coef_q.c6 <= wr_data;
				// unused indexes are dropped
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

// ----- design/bsc_ser_mult.sv -----
// bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
`timescale 1ns / 1ps

module bsc_ser_mult (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bsc_pkg::mul_cmd_t                     cmd,
	input  logic signed [bsc_pkg::MCAND_W-1:0]    mcand,
	input  logic [bsc_pkg::MPL_W-1:0]             mplier,
	output bsc_pkg::mul_sts_t                     sts,
	output logic signed [bsc_pkg::PROD_W-1:0]     prod
);
	import bsc_pkg::*;

	logic signed [MCAND_W-1:0] mcand_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [MPL_W-1:0]          mpl_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic signed [ACC_W-1:0]   addend;
	logic signed [ACC_W-1:0]   sum;

	// one multiplier bit per cycle; low product bits shift in at the top of mpl_q
	assign addend = mpl_q[0] ? {mcand_q[MCAND_W-1], mcand_q} : '0;
	assign sum    = acc_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			done_q  <= 1'b0;
			mcand_q <= '0;
			acc_q   <= '0;
			mpl_q   <= '0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (cmd.start) begin
				cnt_q   <= cmd.nbits;
				mcand_q <= mcand;
				acc_q   <= '0;
				mpl_q   <= mplier;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				acc_q <= {sum[ACC_W-1], sum[ACC_W-1:1]};
				mpl_q <= {sum[0], mpl_q[MPL_W-1:1]};
			end
		end
	end

	// with an n-bit multiplier the product comes out scaled by 2^(MPL_W-n)
	assign prod     = {acc_q, mpl_q};
	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;

endmodule

// ----- design/baro_sensor_compensation.sv -----
// top level: sample sequencer, compensation arithmetic and result register
`timescale 1ns / 1ps

// Compensates raw barometric sensor conversions with six calibration words.
// A temperature sample updates the stored temperature difference and returns
// the temperature in 0.01 degC; a pressure sample uses the last stored
// difference and returns pressure in Pa. One item is worked at a time through
// a single bit-serial multiplier that retires one multiplier bit per cycle:
// a temperature sample needs one product with a 16-bit multiplier and a pressure
// sample two products with a 16-bit multiplier and one with a 24-bit one. The
// result register frees the sequencer, so the next sample can be taken the
// cycle after a result is loaded, even while that result still waits on
// out_ready. Coefficient writes complete at once and are expected only while
// no sample is in progress.

module baro_sensor_compensation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 opcode,
	input  logic [bsc_pkg::RAW_W-1:0]            raw_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 result_kind,
	output logic signed [bsc_pkg::VAL_W-1:0]     value,
	output logic                                 quality,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bsc_pkg::COEF_W-1:0]           cfg_data
);
	import bsc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_TEMP,
		S_OFF,
		S_SENS,
		S_PRES,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic                       kind_q;
	logic [RAW_W-1:0]           raw_q;
	logic signed [DT_W-1:0]     dt_q;
	logic signed [MCAND_W-1:0]  off_q;
	logic signed [VAL_W-1:0]    calc_q;
	logic                       out_valid_q;
	logic                       out_kind_q;
	logic signed [VAL_W-1:0]    out_value_q;
	logic                       out_quality_q;

	coef_t                      coef;
	mul_cmd_t                   mul_cmd;
	mul_sts_t                   mul_sts;
	logic signed [MCAND_W-1:0]  mul_mcand;
	logic [MPL_W-1:0]           mul_mplier;
	logic signed [PROD_W-1:0]   prod;

	logic signed [DT_W-1:0]     dt_new;
	logic signed [MCAND_W-1:0]  dt_ext;
	logic signed [PROD_W-1:0]   temp_sh;
	logic signed [PROD_W-1:0]   off_sh;
	logic signed [PROD_W-1:0]   sens_sh;
	logic signed [PROD_W-1:0]   pres_sh;
	logic signed [MCAND_W-1:0]  off_new;
	logic signed [MCAND_W-1:0]  sens_new;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [DIFF_W-1:0]   diff_sh;
	logic signed [VAL_W-1:0]    temp_val;
	logic signed [VAL_W-1:0]    pres_val;
	logic                       full;
	logic                       out_load;

	bsc_coef_regs u_coef_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	bsc_ser_mult u_ser_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.sts    (mul_sts),
		.prod   (prod)
	);

	assign dt_new = $signed({1'b0, raw_sample})
		- $signed({1'b0, coef.c5, {C5_SHIFT{1'b0}}});
	assign dt_ext = {{(MCAND_W - DT_W){dt_q[DT_W-1]}}, dt_q};

	assign temp_sh  = prod >>> TEMP_SHIFT;
	assign off_sh   = prod >>> OFF_SHIFT;
	assign sens_sh  = prod >>> SENS_SHIFT;
	assign pres_sh  = prod >>> PRES_SHIFT;

	assign temp_val = temp_sh[VAL_W-1:0] + TEMP_OFFSET;
	assign off_new  = {{(MCAND_W - COEF_W - C2_SHIFT){1'b0}}, coef.c2, {C2_SHIFT{1'b0}}}
		+ off_sh[MCAND_W-1:0];
	assign sens_new = {{(MCAND_W - COEF_W - C1_SHIFT){1'b0}}, coef.c1, {C1_SHIFT{1'b0}}}
		+ sens_sh[MCAND_W-1:0];
	assign diff     = pres_sh[DIFF_W-1:0] - {{(DIFF_W - MCAND_W){off_q[MCAND_W-1]}}, off_q};
	assign diff_sh  = diff >>> FINAL_SHIFT;
	assign pres_val = diff_sh[VAL_W-1:0];

	// multiplier operand selection; the first product starts in S_START, each later one on the previous done
	always_comb begin
		mul_cmd       = '0;
		mul_cmd.nbits = CNT_W'(COEF_W);
		mul_mcand     = dt_ext;
		mul_mplier    = {{(MPL_W - COEF_W){1'b0}}, coef.c6};
		unique case (state_q)
			S_START: begin
				mul_cmd.start = 1'b1;
				if (kind_q == KIND_PRES) begin
					mul_mplier = {{(MPL_W - COEF_W){1'b0}}, coef.c4};
				end
			end
			S_OFF: begin
				mul_cmd.start = mul_sts.done;
				mul_mplier    = {{(MPL_W - COEF_W){1'b0}}, coef.c3};
			end
			S_SENS: begin
				mul_cmd.start = mul_sts.done;
				mul_cmd.nbits = CNT_W'(RAW_W);
				mul_mcand     = sens_new;
				mul_mplier    = raw_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (kind_q == KIND_PRES) begin
			full = (calc_q > PRES_MIN) && (calc_q < PRES_MAX);
		end else begin
			full = (calc_q > TEMP_MIN) && (calc_q < TEMP_MAX);
		end
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= KIND_TEMP;
			raw_q         <= '0;
			dt_q          <= '0;
			off_q         <= '0;
			calc_q        <= '0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= KIND_TEMP;
			out_value_q   <= '0;
			out_quality_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= opcode;
						raw_q   <= raw_sample;
						if (opcode == KIND_TEMP) begin
							dt_q <= dt_new;
						end
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= (kind_q == KIND_PRES) ? S_OFF : S_TEMP;
				end
				S_TEMP: begin
					if (mul_sts.done) begin
						calc_q  <= temp_val;
						state_q <= S_DONE;
					end
				end
				S_OFF: begin
					if (mul_sts.done) begin
						off_q   <= off_new;
						state_q <= S_SENS;
					end
				end
				S_SENS: begin
					if (mul_sts.done) begin
						state_q <= S_PRES;
					end
				end
				S_PRES: begin
					if (mul_sts.done) begin
						calc_q  <= pres_val;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_kind_q    <= kind_q;
						out_value_q   <= calc_q;
						out_quality_q <= ~full;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign value       = out_value_q;
	assign quality     = out_quality_q;

	// a product is never restarted while the serial unit is still stepping
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_cmd.start |-> !mul_sts.busy)
		else $error("multiplier started while busy");

	// no new sample is taken while a product is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.busy |-> !in_ready)
		else $error("sample taken during multiplication");

	// multiplier completion only lands in a state that consumes it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |-> (state_q == S_TEMP || state_q == S_OFF
			|| state_q == S_SENS || state_q == S_PRES))
		else $error("multiplier result dropped");

	// a finished result reaches the output register and frees the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && state_q == S_IDLE))
		else $error("result not loaded");

endmodule
